// ===== src/rtpc_pkg.sv =====
// ----------------------------------------------------------------------------
// rtpc_pkg
// Shared types and constants for the radio time pulse classifier.
// ----------------------------------------------------------------------------
package rtpc_pkg;

    // Width of the saturating tick counter.
    localparam int COUNT_WIDTH = 16;

    // Width of every configuration register.
    localparam int CFG_WIDTH = 16;

    // Number of configuration registers, and the index width of the port.
    localparam int CFG_COUNT = 5;
    localparam int CFG_INDEX_WIDTH = $clog2(CFG_COUNT);

    // Comparisons are made one bit wider than the widest operand, so that
    // a nominal value plus the tolerance never wraps.
    localparam int CMP_WIDTH = ((COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH) + 1;

    // Saturation value of the tick counter.
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_TOLERANCE  = CFG_INDEX_WIDTH'(0),
        CFG_ZERO_PULSE = CFG_INDEX_WIDTH'(1),
        CFG_ONE_PULSE  = CFG_INDEX_WIDTH'(2),
        CFG_SECOND     = CFG_INDEX_WIDTH'(3),
        CFG_MINUTE     = CFG_INDEX_WIDTH'(4)
    } cfg_index_t;

    // Reset values of the configuration registers.
    localparam logic [CFG_WIDTH-1:0] RESET_TOLERANCE  = CFG_WIDTH'(50);
    localparam logic [CFG_WIDTH-1:0] RESET_ZERO_PULSE = CFG_WIDTH'(100);
    localparam logic [CFG_WIDTH-1:0] RESET_ONE_PULSE  = CFG_WIDTH'(200);
    localparam logic [CFG_WIDTH-1:0] RESET_SECOND     = CFG_WIDTH'(1000);
    localparam logic [CFG_WIDTH-1:0] RESET_MINUTE     = CFG_WIDTH'(2000);

    // Event codes on the result channel.
    typedef enum logic [1:0] {
        EV_BIT0   = 2'd0,
        EV_BIT1   = 2'd1,
        EV_MINUTE = 2'd2,
        EV_ERROR  = 2'd3
    } event_code_t;

endpackage

// ===== src/radio_time_pulse_classifier.sv =====
// ----------------------------------------------------------------------------
// radio_time_pulse_classifier
// Pulse-width decoder for a long-wave time signal, one level sample per tick.
// ----------------------------------------------------------------------------
// The block takes one receiver level sample per clock cycle when the input is
// not stalled, and classifies each carrier-reduction edge in the same cycle it
// is accepted: a falling edge reports bit zero, bit one or a timing error from
// the pulse length, and a rising edge reports a new minute or a timing error
// from the spacing to the previous rising edge (a normal second gives no
// result). An accepted result is registered in the output register, or in
// the skid register while the output register still holds one; the two let
// the input keep flowing while a result waits; it stalls only when both hold
// results. Configuration registers are written through the plain write port;
// the user must write them only while the block is idle; it is not enforced.
module radio_time_pulse_classifier
    import rtpc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,

    // Sample channel.
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       carrier_reduced,

    // Result channel.
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 event_code,

    // Configuration write port.
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_data
);

    // Configuration registers.
    logic [CFG_WIDTH-1:0] tolerance_reg;
    logic [CFG_WIDTH-1:0] zero_pulse_reg;
    logic [CFG_WIDTH-1:0] one_pulse_reg;
    logic [CFG_WIDTH-1:0] second_period_reg;
    logic [CFG_WIDTH-1:0] minute_period_reg;

    // Decoder state.
    logic                   in_pulse_reg;
    logic                   in_pulse_next;
    logic [COUNT_WIDTH-1:0] elapsed_reg;
    logic [COUNT_WIDTH-1:0] elapsed_next;

    // Output and skid stages.
    logic        out_valid_reg;
    event_code_t out_code_reg;
    logic        skid_valid_reg;
    event_code_t skid_code_reg;

    // Classification of the accepted sample.
    logic                   accept;
    logic                   rising;
    logic                   falling;
    logic                   near_zero;
    logic                   near_one;
    logic                   near_second;
    logic                   near_minute;
    logic                   result_valid;
    event_code_t            result_code;
    logic [COUNT_WIDTH-1:0] count_base;
    logic                   out_take;

    // True when x lies within the tolerance of the nominal value, inclusive.
    function automatic logic near_value(
        input logic [COUNT_WIDTH-1:0] x,
        input logic [CFG_WIDTH-1:0]   nominal,
        input logic [CFG_WIDTH-1:0]   tol
    );
        logic [CMP_WIDTH-1:0] xw;
        logic [CMP_WIDTH-1:0] nw;
        logic [CMP_WIDTH-1:0] tw;
        xw = CMP_WIDTH'(x);
        nw = CMP_WIDTH'(nominal);
        tw = CMP_WIDTH'(tol);
        return (xw <= nw + tw) && (nw <= xw + tw);
    endfunction

    assign accept   = in_valid && !in_stall;
    assign in_stall = skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;

    // Edge detection and window checks against the current count.
    assign rising      = !in_pulse_reg && carrier_reduced;
    assign falling     = in_pulse_reg && !carrier_reduced;
    assign near_zero   = near_value(elapsed_reg, zero_pulse_reg, tolerance_reg);
    assign near_one    = near_value(elapsed_reg, one_pulse_reg, tolerance_reg);
    assign near_second = near_value(elapsed_reg, second_period_reg, tolerance_reg);
    assign near_minute = near_value(elapsed_reg, minute_period_reg, tolerance_reg);

    // Result selection; the minute window wins over the second window and
    // the zero window wins over the one window.
    always_comb
    begin
        result_valid = 1'b0;
        result_code  = EV_ERROR;
        if (rising)
        begin
            if (near_minute)
            begin
                result_valid = 1'b1;
                result_code  = EV_MINUTE;
            end
            else if (!near_second)
            begin
                result_valid = 1'b1;
                result_code  = EV_ERROR;
            end
        end
        else if (falling)
        begin
            result_valid = 1'b1;
            if (near_zero)
            begin
                result_code = EV_BIT0;
            end
            else if (near_one)
            begin
                result_code = EV_BIT1;
            end
            else
            begin
                result_code = EV_ERROR;
            end
        end
    end

    // Next state: a rising edge restarts the count, then it counts up
    // with saturation.
    always_comb
    begin
        in_pulse_next = in_pulse_reg;
        elapsed_next  = elapsed_reg;
        if (accept)
        begin
            in_pulse_next = carrier_reduced;
            count_base    = rising ? '0 : elapsed_reg;
            if (count_base != COUNT_MAX)
            begin
                elapsed_next = count_base + COUNT_WIDTH'(1);
            end
            else
            begin
                elapsed_next = count_base;
            end
        end
        else
        begin
            count_base = elapsed_reg;
        end
    end

    // Decoder state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_pulse_reg <= 1'b0;
            elapsed_reg  <= '0;
        end
        else
        begin
            in_pulse_reg <= in_pulse_next;
            elapsed_reg  <= elapsed_next;
        end
    end

    // Configuration registers; writes beyond the last index are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg     <= RESET_TOLERANCE;
            zero_pulse_reg    <= RESET_ZERO_PULSE;
            one_pulse_reg     <= RESET_ONE_PULSE;
            second_period_reg <= RESET_SECOND;
            minute_period_reg <= RESET_MINUTE;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_TOLERANCE:  tolerance_reg     <= cfg_data;
                CFG_ZERO_PULSE: zero_pulse_reg    <= cfg_data;
                CFG_ONE_PULSE:  one_pulse_reg     <= cfg_data;
                CFG_SECOND:     second_period_reg <= cfg_data;
                CFG_MINUTE:     minute_period_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Output register and skid register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept && result_valid)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output and skid payload.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_code_reg <= skid_code_reg;
            end
        end
        else if (accept && result_valid)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_code_reg <= result_code;
            end
            else
            begin
                skid_code_reg <= result_code;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_code = out_code_reg;

    // The skid register is only ever filled behind a full output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output is empty");

    // A held result in the skid register is not dropped while the output stalls.
    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_stall) |=> (skid_valid_reg && $stable(skid_code_reg)))
        else $error("skid result lost during an output stall");

    // After every accepted falling edge the output register holds a result in the next cycle.
    a_falling_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && falling) |=> out_valid_reg)
        else $error("falling edge produced no result");

    // A rising edge restarts the count, so it reads one afterwards.
    a_rising_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && rising) |=> (elapsed_reg == COUNT_WIDTH'(1) && in_pulse_reg))
        else $error("tick counter not restarted on a rising edge");

endmodule
